// ===== design/twq_pkg.sv =====
// Package with shared types and constants of the timed wait queue.
package twq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int THREAD_W = 16;
  localparam int TIMER_W  = 16;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RSN_TAKEN   = 2'd0,
    RSN_TIMEOUT = 2'd1,
    RSN_EMPTY   = 2'd2,
    RSN_FULL    = 2'd3
  } reason_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUT,
    CMD_SHIFT,
    CMD_DECR,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROTATE
  } state_t;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [TIMER_W-1:0]  timer;
    logic                flag;
  } entry_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      hit;
    logic      occ;
  } cell_ctl_t;

endpackage

// ===== design/twq_if.sv =====
// Request and response channel interfaces of the timed wait queue.
interface twq_req_if;
  import twq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [THREAD_W-1:0] thread_id;
  logic [TIMER_W-1:0]  wait_time;
  modport source (output valid, opcode, thread_id, wait_time, input ready);
  modport sink (input valid, opcode, thread_id, wait_time, output ready);
endinterface

interface twq_rsp_if;
  import twq_pkg::*;
  logic                valid;
  logic                ready;
  logic [THREAD_W-1:0] released_thread;
  logic [1:0]          reason;
  logic [COUNT_W-1:0]  threads_waiting;
  logic                last;
  modport source (output valid, released_thread, reason, threads_waiting, last, input ready);
  modport sink (input valid, released_thread, reason, threads_waiting, last, output ready);
endinterface

// ===== design/twq_cell.sv =====
// One queue position: holds a thread, its timer and an expiry flag.
module twq_cell
  import twq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    load,
  input  entry_t    nb,
  output entry_t    ent,
  output logic      expire
);

  entry_t ent_next;

  assign expire = ctl.occ && (ent.timer == TIMER_W'(1));

  always_comb begin
    ent_next = ent;
    case (ctl.cmd)
      CMD_PUT: begin
        if (ctl.hit) begin
          ent_next = load;
        end
      end
      CMD_SHIFT: begin
        ent_next = nb;
      end
      CMD_DECR: begin
        if (ent.timer != '0) begin
          ent_next.timer = ent.timer - TIMER_W'(1);
        end
        ent_next.flag = expire;
      end
      CMD_ROTATE: begin
        ent_next = ctl.hit ? load : nb;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent.thread <= ent_next.thread;
    ent.timer  <= ent_next.timer;
    if (rst) begin
      ent.flag <= 1'b0;
    end else begin
      ent.flag <= ent_next.flag;
    end
  end

endmodule

// ===== design/timed_wait_queue_top.sv =====
// Top level of the timed wait queue: control, response register and the cell row.
// A get or a rejected put gives its word in the cycle after acceptance; an accepted put gives none.
// A tick counts the timers down; if a thread times out, the row then rotates through
// cell 0 once per thread waiting at the tick, each timed-out thread leaving as a word; a
// rotation waits while the response word is stalled.
// Reset clears the count, the control state, the expiry flags and the response valid.
module timed_wait_queue_top
  import twq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic   clk,
  input logic   rst,
  twq_req_if.sink   req,
  twq_rsp_if.source rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW-1:0] count_dec;

  logic                out_valid, out_valid_next;
  logic [THREAD_W-1:0] out_thread, out_thread_next;
  reason_t             out_reason, out_reason_next;
  logic [CW-1:0]       out_count, out_count_next;
  logic                out_last, out_last_next;

  cell_cmd_t cmd;
  entry_t    load;
  entry_t    ents [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] expires;
  logic [QUEUE_DEPTH-1:0] flags;
  logic out_free, acc, tail_expired;

  assign count_dec = count - CW'(1);
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      flags[k] = ents[k].flag;
    end
  end
  assign tail_expired = |(flags >> 1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    rem_next        = rem;
    cmd             = CMD_HOLD;
    load            = '{thread: req.thread_id, timer: req.wait_time, flag: 1'b0};
    out_valid_next  = out_valid && !rsp.ready;
    out_thread_next = out_thread;
    out_reason_next = out_reason;
    out_count_next  = out_count;
    out_last_next   = out_last;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (opcode_t'(req.opcode))
            OP_PUT: begin
              if (count >= CW'(QUEUE_DEPTH)) begin
                out_valid_next  = 1'b1;
                out_thread_next = req.thread_id;
                out_reason_next = RSN_FULL;
                out_count_next  = count;
                out_last_next   = 1'b1;
              end else begin
                cmd        = CMD_PUT;
                count_next = count + CW'(1);
              end
            end
            OP_GET: begin
              out_valid_next = 1'b1;
              out_last_next  = 1'b1;
              if (count == '0) begin
                out_thread_next = '0;
                out_reason_next = RSN_EMPTY;
                out_count_next  = '0;
              end else begin
                cmd             = CMD_SHIFT;
                count_next      = count_dec;
                out_thread_next = ents[0].thread;
                out_reason_next = RSN_TAKEN;
                out_count_next  = count_dec;
              end
            end
            OP_TICK: begin
              cmd = CMD_DECR;
              if (|expires) begin
                state_next = ST_ROTATE;
                rem_next   = count;
              end
            end
            default: begin
              cmd = CMD_HOLD;
            end
          endcase
        end
      end
      ST_ROTATE: begin
        if (out_free) begin
          cmd      = CMD_ROTATE;
          load     = '{thread: ents[0].thread, timer: ents[0].timer, flag: 1'b0};
          rem_next = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = ST_IDLE;
          end
          if (ents[0].flag) begin
            count_next      = count_dec;
            out_valid_next  = 1'b1;
            out_thread_next = ents[0].thread;
            out_reason_next = RSN_TIMEOUT;
            out_count_next  = count_dec;
            out_last_next   = !tail_expired;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    cell_ctl_t ctl;
    entry_t    nb;

    always_comb begin
      ctl.cmd = cmd;
      ctl.occ = IDX < count;
      case (cmd)
        CMD_PUT:    ctl.hit = (IDX == count);
        CMD_ROTATE: ctl.hit = !ents[0].flag && (IDX == count_dec);
        default:    ctl.hit = 1'b0;
      endcase
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = ents[i+1];
    end

    twq_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .load   (load),
      .nb     (nb),
      .ent    (ents[i]),
      .expire (expires[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      out_valid <= out_valid_next;
    end
    out_thread <= out_thread_next;
    out_reason <= out_reason_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

  assign rsp.valid           = out_valid;
  assign rsp.released_thread = out_thread;
  assign rsp.reason          = out_reason;
  assign rsp.threads_waiting = COUNT_W'(out_count);
  assign rsp.last            = out_last;

endmodule

// ===== design/twq_checker.sv =====
// Port-level checks of the timed wait queue, bound to the top level.
module twq_checker
  import twq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [THREAD_W-1:0] rsp_thread,
  input logic [1:0]          rsp_reason,
  input logic [COUNT_W-1:0]  rsp_count,
  input logic                rsp_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_thread) && $stable(rsp_reason))
    else $error("response word changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_reason != RSN_TIMEOUT) |-> rsp_last)
    else $error("get or reject word not marked last");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_reason == RSN_EMPTY) |-> (rsp_thread == '0) && (rsp_count == '0))
    else $error("empty get word carries a thread or count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_reason == RSN_FULL) |-> (rsp_count == COUNT_W'(QUEUE_DEPTH)))
    else $error("put rejected while queue not full");

endmodule

bind timed_wait_queue_top twq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_twq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_thread (rsp.released_thread),
  .rsp_reason (rsp.reason),
  .rsp_count  (rsp.threads_waiting),
  .rsp_last   (rsp.last)
);
